[design/mlfq_pkg.sv]
package mlfq_pkg;

    typedef enum logic [2:0] {
        ACT_LOAD    = 3'd0,
        ACT_UNBLOCK = 3'd1,
        ACT_TICK    = 3'd2,
        ACT_BLOCK   = 3'd3,
        ACT_EXIT    = 3'd4
    } action_t;

    localparam int unsigned ID_W = 6;
    localparam int unsigned ID_SPACE = 64;
    localparam int unsigned QUANTUM_W = 8;
    localparam int unsigned LEVELS_W = 3;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Q2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Q3     = 3'd4;

    // classified item passed from front to back
    typedef struct packed {
        logic [2:0]      action;
        logic [ID_W-1:0] task_id;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DECODE,
        ST_POP_WAIT,
        ST_UNBLOCK_WAIT,
        ST_RESULT
    } state_t;

endpackage

[design/mlfq_front.sv]
module mlfq_front
    import mlfq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] in_action,
    input  logic [ID_W-1:0] in_task_id,
    output logic       q_valid,
    input  logic       q_ready,
    output cmd_t       q_cmd
);

    // two-entry queue between front and back
    cmd_t       buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // store accepted item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= '{action: in_action, task_id: in_task_id};
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[design/mlfq_back.sv]
module mlfq_back
    import mlfq_pkg::*;
#(
    parameter int unsigned NUM_LEVELS = 4,
    parameter int unsigned TASK_SLOTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  cmd_t                 q_cmd,
    input  logic [LEVELS_W-1:0]  levels_in_use,
    input  logic [QUANTUM_W-1:0] quanta [4],
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ID_W-1:0]      out_next_task,
    output logic                 out_is_idle,
    output logic                 out_status
);

    localparam int unsigned LV_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
    localparam int unsigned CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int unsigned ADDR_W = LV_W + SLOT_W;
    localparam int unsigned DEPTH  = (1 << LV_W) * (1 << SLOT_W);

    // ready queue memory, level in the upper address bits
    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;
    logic            wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [ID_W-1:0] wr_data;
    logic            rd_en;

    logic [SLOT_W-1:0] head_reg [NUM_LEVELS];
    logic [SLOT_W-1:0] tail_reg [NUM_LEVELS];
    logic [CNT_W-1:0]  count_reg [NUM_LEVELS];
    logic [SLOT_W-1:0] head_next [NUM_LEVELS];
    logic [SLOT_W-1:0] tail_next [NUM_LEVELS];
    logic [CNT_W-1:0]  count_next [NUM_LEVELS];

    logic [ID_SPACE-1:0] blk_flag_reg, blk_flag_next;
    logic [LV_W-1:0]     blk_lvl [ID_SPACE];
    logic [LV_W-1:0]     blk_rd_reg;
    logic                blk_wr;
    logic [ID_W-1:0]     blk_wr_id;
    logic [LV_W-1:0]     blk_wr_lvl;

    logic [ID_W-1:0]      run_task_reg, run_task_next;
    logic                 run_valid_reg, run_valid_next;
    logic [LV_W-1:0]      run_lvl_reg, run_lvl_next;
    logic [QUANTUM_W-1:0] qleft_reg, qleft_next;

    state_t          state_reg, state_next;
    logic [ID_W-1:0] unblk_id_reg, unblk_id_next;
    logic [ID_W-1:0] res_task_reg, res_task_next;
    logic            res_idle_reg, res_idle_next;
    logic            res_status_reg, res_status_next;

    assign out_valid     = (state_reg == ST_RESULT);
    assign out_next_task = res_task_reg;
    assign out_is_idle   = res_idle_reg;
    assign out_status    = res_status_reg;
    assign q_ready       = (state_reg == ST_DECODE);

    // memory ports; return level is read into a register
    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
        if (blk_wr) blk_lvl[blk_wr_id] <= blk_wr_lvl;
        blk_rd_reg <= blk_lvl[q_cmd.task_id];
    end

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] p);
        return (32'(p) + 1 >= TASK_SLOTS) ? '0 : p + 1'b1;
    endfunction

    // clamp active level count
    logic [LV_W:0] act_lv;
    always_comb
    begin
        if (levels_in_use == '0)
            act_lv = (LV_W+1)'(1);
        else if (32'(levels_in_use) > NUM_LEVELS)
            act_lv = (LV_W+1)'(NUM_LEVELS);
        else
            act_lv = (LV_W+1)'(levels_in_use);
    end

    // decode, push, start dispatch
    always_comb
    begin
        logic            do_push;
        logic [LV_W-1:0] push_lvl;
        logic [ID_W-1:0] push_id;
        logic            do_disp;
        logic            push_ok;
        logic            found;
        logic [LV_W-1:0] sel;
        logic [LV_W:0]   nl;
        logic            unblk_wait;
        do_push = 1'b0;
        push_lvl = '0;
        push_id = '0;
        do_disp = 1'b0;
        push_ok = 1'b0;
        found = 1'b0;
        sel = '0;
        nl = '0;
        unblk_wait = 1'b0;

        state_next      = state_reg;
        unblk_id_next   = unblk_id_reg;
        res_task_next   = res_task_reg;
        res_idle_next   = res_idle_reg;
        res_status_next = res_status_reg;
        run_task_next   = run_task_reg;
        run_valid_next  = run_valid_reg;
        run_lvl_next    = run_lvl_reg;
        qleft_next      = qleft_reg;
        blk_flag_next   = blk_flag_reg;
        blk_wr = 1'b0;
        blk_wr_id = run_task_reg;
        blk_wr_lvl = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
        end
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en = 1'b0;
        rd_addr = '0;

        case (state_reg)
            ST_DECODE:
            begin
                if (q_valid)
                begin
                    res_status_next = 1'b0;
                    case (q_cmd.action)
                        ACT_LOAD:
                        begin
                            do_push = 1'b1;
                            push_id = q_cmd.task_id;
                        end
                        ACT_UNBLOCK:
                        begin
                            // re-queue after the return level is read
                            if (blk_flag_reg[q_cmd.task_id])
                            begin
                                blk_flag_next[q_cmd.task_id] = 1'b0;
                                unblk_id_next = q_cmd.task_id;
                                unblk_wait = 1'b1;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                            end
                        end
                        ACT_TICK:
                        begin
                            if (!run_valid_reg)
                                do_disp = 1'b1;
                            else if (qleft_reg != '0)
                            begin
                                qleft_next = qleft_reg - 1'b1;
                                if (qleft_reg == QUANTUM_W'(1))
                                begin
                                    nl = {1'b0, run_lvl_reg};
                                    if (nl + 1'b1 < act_lv) nl = nl + 1'b1;
                                    do_push = 1'b1;
                                    push_lvl = LV_W'(nl);
                                    push_id = run_task_reg;
                                    do_disp = 1'b1;
                                end
                            end
                        end
                        ACT_BLOCK:
                        begin
                            if (run_valid_reg)
                            begin
                                blk_flag_next[run_task_reg] = 1'b1;
                                blk_wr = 1'b1;
                                blk_wr_lvl = (run_lvl_reg == '0) ? '0
                                           : run_lvl_reg - 1'b1;
                            end
                            do_disp = 1'b1;
                        end
                        ACT_EXIT:
                        begin
                            do_disp = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    // push into ready queue
                    if (do_push && 32'(count_reg[push_lvl]) < TASK_SLOTS)
                    begin
                        push_ok = 1'b1;
                        wr_en = 1'b1;
                        wr_addr = {push_lvl, tail_reg[push_lvl]};
                        wr_data = push_id;
                        tail_next[push_lvl]  = wrap_inc(tail_reg[push_lvl]);
                        count_next[push_lvl] = count_reg[push_lvl] + 1'b1;
                    end

                    // pick the lowest-numbered non-empty level
                    for (int i = NUM_LEVELS - 1; i >= 0; i--)
                    begin
                        if (count_next[i] != '0)
                        begin
                            found = 1'b1;
                            sel = LV_W'(i);
                        end
                    end

                    if (do_disp && found)
                    begin
                        // read head; bypass a same-cycle write to that slot
                        rd_en = !(push_ok && push_lvl == sel
                                  && tail_reg[sel] == head_reg[sel]);
                        rd_addr = {sel, head_reg[sel]};
                        head_next[sel]  = wrap_inc(head_reg[sel]);
                        count_next[sel] = count_next[sel] - 1'b1;
                        run_valid_next = 1'b1;
                        run_lvl_next = sel;
                        qleft_next = quanta[(32'(sel) < 4) ? 2'(sel) : 2'd3];
                        if (!rd_en) run_task_next = push_id;
                        state_next = rd_en ? ST_POP_WAIT : ST_RESULT;
                        res_task_next = push_id;
                        res_idle_next = 1'b0;
                    end
                    else
                    begin
                        if (do_disp)
                        begin
                            run_valid_next = 1'b0;
                            run_task_next = '0;
                            run_lvl_next = '0;
                            qleft_next = '0;
                        end
                        res_task_next = run_valid_next ? run_task_next : '0;
                        res_idle_next = !run_valid_next;
                        state_next = ST_RESULT;
                    end

                    if (unblk_wait) state_next = ST_UNBLOCK_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                run_task_next = rd_data_reg;
                res_task_next = rd_data_reg;
                state_next = ST_RESULT;
            end
            ST_UNBLOCK_WAIT:
            begin
                // push the unblocked task at its return level
                if (32'(blk_rd_reg) < NUM_LEVELS
                    && 32'(count_reg[blk_rd_reg]) < TASK_SLOTS)
                begin
                    wr_en = 1'b1;
                    wr_addr = {blk_rd_reg, tail_reg[blk_rd_reg]};
                    wr_data = unblk_id_reg;
                    tail_next[blk_rd_reg]  = wrap_inc(tail_reg[blk_rd_reg]);
                    count_next[blk_rd_reg] = count_reg[blk_rd_reg] + 1'b1;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_ready) state_next = ST_DECODE;
            end
            default:
            begin
                state_next = ST_DECODE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DECODE;
            unblk_id_reg <= '0;
            res_task_reg <= '0;
            res_idle_reg <= 1'b1;
            res_status_reg <= 1'b0;
            run_task_reg <= '0;
            run_valid_reg <= 1'b0;
            run_lvl_reg <= '0;
            qleft_reg <= '0;
            blk_flag_reg <= '0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unblk_id_reg <= unblk_id_next;
            res_task_reg <= res_task_next;
            res_idle_reg <= res_idle_next;
            res_status_reg <= res_status_next;
            run_task_reg <= run_task_next;
            run_valid_reg <= run_valid_next;
            run_lvl_reg <= run_lvl_next;
            qleft_reg <= qleft_next;
            blk_flag_reg <= blk_flag_next;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

[design/multilevel_feedback_queue_scheduler.sv]
// Channel  Direction  tdata bits (low first)          tuser
// s_axis   in         action[2:0], task_id[8:3]       -
// m_axis   out        next_task[5:0], is_idle[6],     -
//                     status[7]
// cfg      in         wr_en, wr_index[2:0], wr_data[7:0]
// The back end handles each item in a decode state and a result state; a dispatch that
// reads the queue memory or an unblock that reads the return-level table adds a wait state.
// An accepted item is registered in the front buffer before it is decoded.
// The front buffer holds two items, so input is taken while a result waits.
// Reset clears queues, blocked flags and the running task; no clearing pass.
module multilevel_feedback_queue_scheduler
    import mlfq_pkg::*;
#(
    parameter int unsigned NUM_LEVELS = 4,
    parameter int unsigned TASK_SLOTS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action[2:0], task_id[8:3]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // next_task[5:0], is_idle[6], status[7]
    input  logic       wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [7:0] wr_data
);

    logic [LEVELS_W-1:0]  levels_reg;
    logic [QUANTUM_W-1:0] quanta_reg [4];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= 3'd4;
            quanta_reg[0] <= 8'd1;
            quanta_reg[1] <= 8'd2;
            quanta_reg[2] <= 8'd4;
            quanta_reg[3] <= 8'd8;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_LEVELS: levels_reg <= wr_data[2:0];
                CFG_Q0:     quanta_reg[0] <= wr_data;
                CFG_Q1:     quanta_reg[1] <= wr_data;
                CFG_Q2:     quanta_reg[2] <= wr_data;
                CFG_Q3:     quanta_reg[3] <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    logic q_valid, q_ready;
    cmd_t q_cmd;
    logic [ID_W-1:0] nt;
    logic idle, stat;

    mlfq_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_action(s_axis_tdata[2:0]), .in_task_id(s_axis_tdata[8:3]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    mlfq_back #(.NUM_LEVELS(NUM_LEVELS), .TASK_SLOTS(TASK_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .levels_in_use(levels_reg), .quanta(quanta_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_next_task(nt), .out_is_idle(idle), .out_status(stat)
    );

    assign m_axis_tdata = {stat, idle, nt};

endmodule

[bench/scheduler_checker.sv]
`timescale 1ns / 100ps

// Watches both streams, keeps its own copy of the scheduler state and
// compares every result item with the one it predicts.
module scheduler_checker
    import mlfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]  wr_data,
    output int          fail_count,
    output int          pending_count
);

    localparam int LVLS  = 4;
    localparam int SLOTS = 64;

    typedef struct packed {
        logic       status;
        logic       is_idle;
        logic [5:0] next_task;
    } sched_result_t;

    logic [5:0] queue_mem [LVLS][SLOTS];
    int         q_head [LVLS];
    int         q_tail [LVLS];
    int         q_count [LVLS];
    logic       blocked [ID_SPACE];
    logic [1:0] return_level [ID_SPACE];
    logic [5:0] cur_task;
    logic       cur_valid;
    logic [1:0] cur_level;
    logic [7:0] ticks_left;
    logic [2:0] levels_reg;
    logic [7:0] quantum_reg [4];

    sched_result_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic void enqueue_task(int lvl, logic [5:0] id);
        if (lvl >= LVLS || q_count[lvl] >= SLOTS)
            return;
        queue_mem[lvl][q_tail[lvl]] = id;
        q_tail[lvl] = (q_tail[lvl] + 1) % SLOTS;
        q_count[lvl]++;
    endfunction

    function automatic void pick_next_task();
        for (int i = 0; i < LVLS; i++)
        begin
            if (q_count[i] > 0)
            begin
                cur_task = queue_mem[i][q_head[i]];
                q_head[i] = (q_head[i] + 1) % SLOTS;
                q_count[i]--;
                cur_valid = 1'b1;
                cur_level = i[1:0];
                ticks_left = quantum_reg[i];
                return;
            end
        end
        cur_valid = 1'b0;
        cur_task = '0;
        cur_level = '0;
        ticks_left = '0;
    endfunction

    function automatic sched_result_t schedule_event(logic [2:0] act, logic [5:0] id);
        sched_result_t r;
        int            lv;
        int            nl;
        r = '0;
        case (act)
            ACT_LOAD:
                enqueue_task(0, id);
            ACT_UNBLOCK:
                if (blocked[id])
                begin
                    blocked[id] = 1'b0;
                    enqueue_task(return_level[id], id);
                end
                else
                    r.status = 1'b1;
            ACT_TICK:
                if (!cur_valid)
                    pick_next_task();
                else if (ticks_left != 0)
                begin
                    ticks_left--;
                    if (ticks_left == 0)
                    begin
                        lv = (levels_reg < 1) ? 1 : (levels_reg > LVLS ? LVLS : levels_reg);
                        nl = cur_level;
                        if (nl + 1 < lv)
                            nl++;
                        enqueue_task(nl, cur_task);
                        pick_next_task();
                    end
                end
            ACT_BLOCK:
            begin
                if (cur_valid)
                begin
                    blocked[cur_task] = 1'b1;
                    return_level[cur_task] = (cur_level == 0) ? 2'd0 : cur_level - 2'd1;
                end
                pick_next_task();
            end
            ACT_EXIT:
                pick_next_task();
            default: ;
        endcase
        r.next_task = cur_valid ? cur_task : 6'd0;
        r.is_idle = !cur_valid;
        return r;
    endfunction

    // Track config writes, predict on input items, compare output items
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t got;
        sched_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LVLS; i++)
            begin
                q_head[i] = 0;
                q_tail[i] = 0;
                q_count[i] = 0;
            end
            for (int i = 0; i < ID_SPACE; i++)
                blocked[i] = 1'b0;
            cur_task = '0;
            cur_valid = 1'b0;
            cur_level = '0;
            ticks_left = '0;
            levels_reg = 3'd4;
            quantum_reg[0] = 8'd1;
            quantum_reg[1] = 8'd2;
            quantum_reg[2] = 8'd4;
            quantum_reg[3] = 8'd8;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == CFG_LEVELS)
                    levels_reg = wr_data[2:0];
                else if (wr_index >= CFG_Q0 && wr_index <= CFG_Q3)
                    quantum_reg[wr_index - CFG_Q0] = wr_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(
                    schedule_event(s_axis_tdata[2:0], s_axis_tdata[8:3]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result item %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.next_task !== want.next_task)
                    begin
                        $display("%0t: next_task expected %0d actual %0d",
                                 $time, want.next_task, got.next_task);
                        fail_count++;
                    end
                    if (got.is_idle !== want.is_idle)
                    begin
                        $display("%0t: is_idle expected %0b actual %0b",
                                 $time, want.is_idle, got.is_idle);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench
    import mlfq_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [7:0]  wr_data;
    int          fail_count;
    int          pending_count;
    logic        calm_mode;
    logic        hold_off_req;

    multilevel_feedback_queue_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    scheduler_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Absolute limit on the run
    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one item, with an occasional idle burst first
    task automatic send_event(action_t act, logic [5:0] id);
        if (!calm_mode && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, id, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
    endtask

    // Wait until every result is back and the block has settled
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_config(logic [2:0] lv, logic [7:0] q0, logic [7:0] q1,
                              logic [7:0] q2, logic [7:0] q3);
        drain_block();
        write_reg(CFG_LEVELS, {5'd0, lv});
        write_reg(CFG_Q0, q0);
        write_reg(CFG_Q1, q1);
        write_reg(CFG_Q2, q2);
        write_reg(CFG_Q3, q3);
        wr_en <= 1'b0;
    endtask

    // Mostly ticks, loads, blocks and exits, plus unblocks and a few undefined actions
    task automatic random_phase(int count);
        int     pick;
        logic [5:0] id;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            id = (pick % 2 == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
            if (pick < 20)
                send_event(ACT_LOAD, id);
            else if (pick < 32)
                send_event(ACT_UNBLOCK, id);
            else if (pick < 70)
                send_event(ACT_TICK, 6'($urandom));
            else if (pick < 84)
                send_event(ACT_BLOCK, 6'($urandom));
            else if (pick < 97)
                send_event(ACT_EXIT, 6'($urandom));
            else
                send_event(action_t'(3'($urandom_range(5, 7))), id);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (60) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!calm_mode && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        calm_mode = 1'b0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: idle ops, unknown unblock, loads, expiry, block/unblock, undefined actions, exits
        send_event(ACT_TICK, 6'd0);
        send_event(ACT_BLOCK, 6'd0);
        send_event(ACT_EXIT, 6'd0);
        send_event(ACT_UNBLOCK, 6'd63);
        send_event(ACT_LOAD, 6'd63);
        send_event(ACT_LOAD, 6'd0);
        send_event(ACT_LOAD, 6'd42);
        send_event(ACT_TICK, 6'd0);
        send_event(ACT_TICK, 6'd0);
        send_event(ACT_TICK, 6'd0);
        send_event(ACT_TICK, 6'd0);
        send_event(ACT_BLOCK, 6'd0);
        send_event(ACT_BLOCK, 6'd0);
        send_event(ACT_UNBLOCK, 6'd0);
        send_event(ACT_UNBLOCK, 6'd63);
        send_event(ACT_UNBLOCK, 6'd42);
        send_event(ACT_UNBLOCK, 6'd21);
        send_event(action_t'(3'd5), 6'd21);
        send_event(action_t'(3'd7), 6'd63);
        send_event(ACT_TICK, 6'd0);
        send_event(ACT_EXIT, 6'd0);
        send_event(ACT_EXIT, 6'd0);
        send_event(ACT_EXIT, 6'd0);

        // Fill level 0 past its depth while results are held off
        hold_off_req = 1'b1;
        for (int i = 0; i < 70; i++)
            send_event(ACT_LOAD, 6'(i));
        random_phase(100);

        set_config(3'd1, 8'd0, 8'd0, 8'd0, 8'd0);
        random_phase(100);
        set_config(3'd0, 8'd255, 8'd1, 8'd1, 8'd255);
        random_phase(100);
        set_config(3'd7, 8'd1, 8'd1, 8'd1, 8'd1);
        random_phase(100);
        set_config(3'd2, 8'd3, 8'd0, 8'd2, 8'd5);
        random_phase(100);
        set_config(3'd4, 8'd2, 8'd3, 8'd1, 8'd2);
        calm_mode = 1'b1;
        random_phase(100);

        drain_block();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
